>>> rtl/row_softmax_core_assert.svh
// Assertion macros shared by the row softmax RTL.
`ifndef ROW_SOFTMAX_CORE_ASSERT_SVH
`define ROW_SOFTMAX_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define RSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define RSM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rsm_pkg.sv
// Shared types and constants for the row softmax block.
`timescale 1ns / 1ps
package rsm_pkg;

  localparam int unsigned ExpW = 32;
  localparam int unsigned SumW = 38;
  localparam logic [26:0] OneQ26 = 27'd67108864;
  localparam logic [25:0] Ln2Q26 = 26'd46516320;
  // |v| * 2^16 / Ln2Q26 equals |v| * 2^11 / 1453635; this is floor(2^43 / 1453635).
  localparam logic [22:0] RecipLn2 = 23'd6051101;

  typedef struct packed {
    logic signed [15:0] value;
    logic               row_end;
  } rsm_in_t;

  typedef struct packed {
    logic [16:0] prob;
    logic        last_out;
    logic        clipped;
  } rsm_out_t;

  // Exponent unit to core status.
  typedef struct packed {
    logic            done;
    logic [ExpW-1:0] ev;
    logic            sat;
  } rsm_exp_res_t;

  // Floor(2^30 / k) for k in 1..10, used to divide by the Taylor term index.
  function automatic logic [30:0] recip_k(input logic [3:0] k);
    logic [30:0] r;
    case (k)
      4'd1:    r = 31'd1073741824;
      4'd2:    r = 31'd536870912;
      4'd3:    r = 31'd357913941;
      4'd4:    r = 31'd268435456;
      4'd5:    r = 31'd214748364;
      4'd6:    r = 31'd178956970;
      4'd7:    r = 31'd153391689;
      4'd8:    r = 31'd134217728;
      4'd9:    r = 31'd119304647;
      4'd10:   r = 31'd107374182;
      default: r = 31'd1073741824;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/rsm_exp.sv
// Multi-cycle fixed-point exponential, Q5.10 in, saturating Q16.16 out.
`timescale 1ns / 1ps
module rsm_exp import rsm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] value_i,
  output rsm_exp_res_t       res_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_EST  = 9'b000000010,
    S_CORR = 9'b000000100,
    S_SIGN = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_QEST = 9'b000100000,
    S_QCOR = 9'b001000000,
    S_OUT  = 9'b010000000,
    S_DONE = 9'b100000000
  } exp_state_e;

  exp_state_e        state_q, state_d;
  logic              neg_q, neg_d;
  logic [15:0]       mag_q, mag_d;
  logic [5:0]        qe_q, qe_d;
  logic [5:0]        qf_q, qf_d;
  logic [25:0]       rf_q, rf_d;
  logic signed [6:0] n_q, n_d;
  logic [25:0]       r_q, r_d;
  logic [26:0]       e_q, e_d;
  logic [3:0]        k_q, k_d;
  logic [52:0]       prod_q, prod_d;
  logic [26:0]       qk_q, qk_d;
  logic [ExpW-1:0]   ev_q, ev_d;
  logic              sat_q, sat_d;

  // Datapath terms: range reduction, term quotient and final scaling.
  logic [38:0] est_prod;
  logic [31:0] red_prod;
  logic [31:0] red_rem;
  logic [26:0] t_val;
  logic [57:0] q_prod;
  logic [30:0] qk_prod;
  logic [30:0] q_diff;
  logic [26:0] q_fix;
  logic [2:0]  sh_up;
  logic [6:0]  s_dn;
  logic [4:0]  sh_dn;
  logic [28:0] e_rnd;

  always_comb begin
    // floor(|x| / ln2) estimate, low by at most one
    est_prod = {23'd0, mag_q} * {16'd0, RecipLn2};
    red_prod = {26'd0, qe_q} * {6'd0, Ln2Q26};
    red_rem  = {mag_q, 16'd0} - red_prod;
    // floor(t / k) estimate by reciprocal, low by at most one
    t_val    = prod_q[52:26];
    q_prod   = {31'd0, t_val} * {27'd0, recip_k(k_q)};
    qk_prod  = {4'd0, qk_q} * {27'd0, k_q};
    q_diff   = {4'd0, t_val} - qk_prod;
    q_fix    = (q_diff >= {27'd0, k_q}) ? qk_q + 27'd1 : qk_q;
    // output scaling by 2^(n-10); large right shifts all round to zero
    sh_up    = 3'(n_q - 7'sd10);
    s_dn     = $unsigned(7'sd10 - n_q);
    sh_dn    = (s_dn > 7'd28) ? 5'd28 : s_dn[4:0];
    e_rnd    = ({2'd0, e_q} + (29'd1 << (sh_dn - 5'd1))) >> sh_dn;
  end

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    qe_d    = qe_q;
    qf_d    = qf_q;
    rf_d    = rf_q;
    n_d     = n_q;
    r_d     = r_q;
    e_d     = e_q;
    k_d     = k_q;
    prod_d  = prod_q;
    qk_d    = qk_q;
    ev_d    = ev_q;
    sat_d   = sat_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          neg_d   = value_i[15];
          mag_d   = value_i[15] ? (~$unsigned(value_i) + 16'd1) : $unsigned(value_i);
          state_d = S_EST;
        end
      end
      S_EST: begin
        qe_d    = est_prod[37:32];
        state_d = S_CORR;
      end
      S_CORR: begin
        if (red_rem >= {6'd0, Ln2Q26}) begin
          qf_d = qe_q + 6'd1;
          rf_d = 26'(red_rem - {6'd0, Ln2Q26});
        end else begin
          qf_d = qe_q;
          rf_d = red_rem[25:0];
        end
        state_d = S_SIGN;
      end
      S_SIGN: begin
        // negative x: n = -ceil(|x| / ln2), remainder taken from the top
        if (!neg_q) begin
          n_d = $signed({1'b0, qf_q});
          r_d = rf_q;
        end else if (rf_q == '0) begin
          n_d = -$signed({1'b0, qf_q});
          r_d = '0;
        end else begin
          n_d = -$signed({1'b0, qf_q}) - 7'sd1;
          r_d = Ln2Q26 - rf_q;
        end
        e_d     = OneQ26;
        k_d     = 4'd10;
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = {26'd0, e_q} * {27'd0, r_q};
        state_d = S_QEST;
      end
      S_QEST: begin
        qk_d    = q_prod[56:30];
        state_d = S_QCOR;
      end
      S_QCOR: begin
        e_d = OneQ26 + q_fix;
        if (k_q == 4'd1) begin
          state_d = S_OUT;
        end else begin
          k_d     = k_q - 4'd1;
          state_d = S_MUL;
        end
      end
      S_OUT: begin
        if (n_q >= 7'sd16) begin
          ev_d  = '1;
          sat_d = 1'b1;
        end else if (n_q >= 7'sd10) begin
          ev_d  = {5'd0, e_q} << sh_up;
          sat_d = 1'b0;
        end else begin
          ev_d  = {3'd0, e_rnd};
          sat_d = 1'b0;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    qe_q   <= qe_d;
    qf_q   <= qf_d;
    rf_q   <= rf_d;
    n_q    <= n_d;
    r_q    <= r_d;
    e_q    <= e_d;
    k_q    <= k_d;
    prod_q <= prod_d;
    qk_q   <= qk_d;
    ev_q   <= ev_d;
    sat_q  <= sat_d;
  end

  assign res_o.done = (state_q == S_DONE);
  assign res_o.ev   = ev_q;
  assign res_o.sat  = sat_q;

endmodule

>>> rtl/row_softmax_core.sv
// Row softmax top level: exponent unit, row buffer memory and divider sequencer.
`timescale 1ns / 1ps
// Usage: raise start with an element while busy is low. Each element keeps busy
// high while the exponent unit runs range reduction, ten Taylor terms (multiply,
// quotient estimate, quotient correction) and a scaling and hand-back step, so
// a new element is taken only once the last one is through. On the row's last
// element (or the element that fills MAX_ROW_LEN entries) the block reads the
// row buffer memory back and emits one result per entry, each after a read,
// the read latency, 55 divider steps and the output register. Each result
// appears for one cycle on done_o and cannot be stalled; busy drops with the
// final result of the row.
`include "row_softmax_core_assert.svh"
module row_softmax_core import rsm_pkg::*; #(
  parameter int unsigned MAX_ROW_LEN = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  rsm_in_t  in_i,
  output logic     done_o,
  output rsm_out_t out_o
);

  localparam int unsigned AW = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_ROW_LEN + 1);

  typedef enum logic [5:0] {
    C_IDLE = 6'b000001,
    C_EXP  = 6'b000010,
    C_RD   = 6'b000100,
    C_DIV  = 6'b001000,
    C_EMIT = 6'b010000,
    C_WAIT = 6'b100000
  } core_state_e;

  core_state_e    state_q, state_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic           sat_q, sat_d;
  logic           end_q, end_d;
  logic [54:0]    rem_q, rem_d;
  logic [54:0]    num_q, num_d;
  logic [16:0]    quo_q, quo_d;
  logic [5:0]     dbit_q, dbit_d;
  logic [16:0]    prob_q, prob_d;
  logic           last_q, last_d;
  logic           clip_q, clip_d;

  logic [ExpW-1:0] mem_q [MAX_ROW_LEN];
  logic [ExpW-1:0] rdata_q;
  logic            we;
  rsm_exp_res_t    xres;
  logic            xstart;

  rsm_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (xstart),
    .value_i (in_i.value),
    .res_o   (xres)
  );

  // Row buffer: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) mem_q[cnt_q[AW-1:0]] <= xres.ev;
    rdata_q <= mem_q[idx_q[AW-1:0]];
  end

  assign xstart = start && (state_q == C_IDLE);
  assign we     = (state_q == C_EXP) && xres.done && (cnt_q < CW'(MAX_ROW_LEN));

  // Shift-subtract divider step over the 55-bit numerator.
  logic [55:0] dtrial;
  logic [55:0] ddiff;
  always_comb begin
    dtrial = {rem_q, num_q[54]};
    ddiff  = dtrial - {18'd0, sum_q};
  end

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    sat_d   = sat_q;
    end_d   = end_q;
    rem_d   = rem_q;
    num_d   = num_q;
    quo_d   = quo_q;
    dbit_d  = dbit_q;
    prob_d  = prob_q;
    last_d  = last_q;
    clip_d  = clip_q;
    case (state_q)
      C_IDLE: begin
        if (start) begin
          end_d   = in_i.row_end;
          state_d = C_EXP;
        end
      end
      C_EXP: begin
        if (xres.done) begin
          if (xres.sat) sat_d = 1'b1;
          if (cnt_q < CW'(MAX_ROW_LEN)) begin
            cnt_d = cnt_q + CW'(1);
            sum_d = sum_q + SumW'(xres.ev);
          end
          if (end_q || (cnt_d >= CW'(MAX_ROW_LEN))) begin
            idx_d   = '0;
            state_d = C_RD;
          end else begin
            state_d = C_IDLE;
          end
        end
      end
      C_RD: begin
        state_d = C_WAIT;
      end
      C_WAIT: begin
        num_d   = 55'({rdata_q, 16'd0}) + 55'(sum_q >> 1);
        rem_d   = '0;
        quo_d   = '0;
        dbit_d  = '0;
        state_d = C_DIV;
      end
      C_DIV: begin
        if (!ddiff[55]) begin
          rem_d = ddiff[54:0];
          quo_d = {quo_q[15:0], 1'b1};
        end else begin
          rem_d = dtrial[54:0];
          quo_d = {quo_q[15:0], 1'b0};
        end
        num_d  = {num_q[53:0], 1'b0};
        dbit_d = dbit_q + 6'd1;
        if (dbit_q == 6'd54) state_d = C_EMIT;
      end
      C_EMIT: begin
        prob_d = (sum_q == '0) ? 17'd0 : quo_q;
        last_d = (idx_q + CW'(1) == cnt_q);
        clip_d = sat_q;
        if (idx_q + CW'(1) == cnt_q) begin
          sum_d   = '0;
          cnt_d   = '0;
          sat_d   = 1'b0;
          state_d = C_IDLE;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = C_RD;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      sum_q   <= '0;
      cnt_q   <= '0;
      sat_q   <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      sat_q   <= sat_d;
      done_o  <= (state_q == C_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    end_q  <= end_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    dbit_q <= dbit_d;
    prob_q <= prob_d;
    last_q <= last_d;
    clip_q <= clip_d;
  end

  assign busy           = (state_q != C_IDLE);
  assign out_o.prob     = prob_q;
  assign out_o.last_out = last_q;
  assign out_o.clipped  = clip_q;

  `RSM_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CW'(MAX_ROW_LEN), "count overflow")
  `RSM_ASSERT_NXT(a_emit_done, clk_i, rst_ni, state_q == C_EMIT, done_o, "missing result strobe")
  `RSM_ASSERT_IMP(a_rd_inrow, clk_i, rst_ni, state_q == C_RD, idx_q < cnt_q, "read beyond row")

endmodule

>>> bench/row_softmax_core_test.sv
// Self-checking testbench for the row softmax core: random rows against a built-in predictor.
`timescale 1ns / 1ps
module row_softmax_core_test import rsm_pkg::*; ();

  localparam int RowMax = 64;
  localparam longint Ln2 = 46516320;
  localparam longint unsigned One = 64'd1 << 26;
  localparam int CycleLimit = 2000000;
  localparam int QuietCycles = 200;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  rsm_in_t  in_i = '0;
  logic     done_o;
  rsm_out_t out_o;

  row_softmax_core #(.MAX_ROW_LEN(RowMax)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .in_i  (in_i),
    .done_o(done_o),
    .out_o (out_o)
  );

  always #6 clk_i = ~clk_i;

  rsm_in_t    elem_q[$];      // elements waiting to be sent
  rsm_out_t   prob_q[$];      // probabilities still owed by the block
  logic [31:0] row_exp[RowMax];
  logic [37:0] row_sum = '0;
  int         row_len = 0;
  bit         row_sat = 1'b0;
  int         sent = 0;
  int         mismatches = 0;
  int         cycles = 0;
  bit         took = 1'b0;

  // Fixed-point exp(v) in Q16.16 with saturation flag
  function automatic logic [31:0] exp_fixed(input logic signed [15:0] v, output bit sat);
    longint x, n;
    longint unsigned r, e;
    int s;
    x = longint'(v) * 65536;
    if (x >= 0) n = x / Ln2;
    else n = -((-x + Ln2 - 1) / Ln2);
    r = longint'(x - n * Ln2);
    e = One;
    for (int k = 10; k >= 1; k--) e = One + ((e * r) >> 26) / k;
    sat = 1'b0;
    if (n >= 16) begin
      sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    if (n >= 10) return 32'(e << (n - 10));
    s = 10 - n;
    return 32'((e + (64'd1 << (s - 1))) >> s);
  endfunction

  // Accumulate one element; emit the row's probabilities when it ends
  task automatic softmax_accept(input rsm_in_t item);
    bit sat;
    bit fin;
    logic [31:0] ev;
    longint unsigned p;
    rsm_out_t res;
    ev = exp_fixed(item.value, sat);
    fin = item.row_end;
    if (sat) row_sat = 1'b1;
    if (row_len < RowMax) begin
      row_exp[row_len] = ev;
      row_len++;
      row_sum = row_sum + ev;
    end
    if (row_len >= RowMax) fin = 1'b1;
    if (fin) begin
      for (int i = 0; i < row_len; i++) begin
        p = 0;
        if (row_sum != 0)
          p = ((longint'(row_exp[i]) << 16) + (row_sum >> 1)) / longint'(row_sum);
        res.prob = p[16:0];
        res.last_out = (i + 1 == row_len);
        res.clipped = row_sat;
        prob_q.push_back(res);
      end
      row_sum = '0;
      row_len = 0;
      row_sat = 1'b0;
    end
  endtask

  task automatic add_elem(input int v, input bit last);
    rsm_in_t item;
    item.value = 16'(v);
    item.row_end = last;
    elem_q.push_back(item);
  endtask

  // Accept transactions, predict, and check results
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && start && !busy) begin
      softmax_accept(in_i);
      void'(elem_q.pop_front());
      sent <= sent + 1;
      took <= 1'b1;
    end else begin
      took <= 1'b0;
    end
    if (rst_ni && done_o) begin
      if (prob_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result prob=%0d last=%0b clipped=%0b",
                                       out_o.prob, out_o.last_out, out_o.clipped);
      end else begin
        if (out_o !== prob_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp prob=%0d last=%0b clip=%0b, got prob=%0d last=%0b clip=%0b",
                     prob_q[0].prob, prob_q[0].last_out, prob_q[0].clipped,
                     out_o.prob, out_o.last_out, out_o.clipped);
        end
        void'(prob_q.pop_front());
      end
    end
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Driver: hold a pending transaction, otherwise present the next one or idle
  always @(negedge clk_i) begin
    bit calm;
    bit idle;
    calm = (sent >= 90 && sent < 150);
    idle = !calm && ($urandom_range(99) < 25);
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took) begin
      start <= 1'b1;
    end else if (elem_q.size() > 0 && !idle) begin
      start <= 1'b1;
      in_i <= elem_q[0];
    end else begin
      start <= 1'b0;
    end
  end

  initial begin
    int len;
    int kind;
    int v;
    int total;
    bit full_done;
    // Directed rows: extremes, single element, zero sum, saturation
    add_elem(32767, 1);
    add_elem(-32768, 1);
    add_elem(0, 0); add_elem(1, 0); add_elem(-1, 1);
    add_elem(-32768, 0); add_elem(-20000, 0); add_elem(-12000, 1);
    add_elem(32767, 0); add_elem(0, 0); add_elem(-1024, 0); add_elem(11400, 1);
    add_elem(1024, 0); add_elem(-1024, 0); add_elem(2048, 0); add_elem(-2048, 1);
    add_elem(-10240, 0); add_elem(-7100, 1);
    add_elem(16'h5555, 0); add_elem(-16'sh2AAB, 1);
    // Random rows, one of them filling the buffer without a row end
    total = 20;
    full_done = 1'b0;
    while (total < 200) begin
      len = $urandom_range(1, 12);
      if (!full_done && total > 60) begin
        len = RowMax;
        full_done = 1'b1;
      end
      for (int i = 0; i < len; i++) begin
        kind = $urandom_range(99);
        if (kind < 70) v = $urandom_range(12288) - 6144;
        else if (kind < 90) v = $urandom_range(65535) - 32768;
        else v = $urandom_range(32767, 11000);
        add_elem(v, (len == RowMax) ? 1'b0 : (i == len - 1));
      end
      total += len;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (elem_q.size() == 0 && !start);
    wait (prob_q.size() == 0);
    repeat (QuietCycles) @(posedge clk_i);
    if (mismatches == 0 && prob_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
